@@ src/fcd_pkg.sv @@
// Shared types, constants and the FNV-1a multiply for the frame classifier.
// No dependencies; every other file in src/ imports this package.
package fcd_pkg;

    // Duplicate ring geometry
    localparam int RING_ENTRIES = 8;
    localparam int RING_IDX_W   = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;

    // Field widths
    localparam int CMD_W    = 8;
    localparam int HASH_W   = 32;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int KEY_W    = 2 * CMD_W + HASH_W;

    // FNV-1a 32-bit
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

    // Command byte decode
    localparam logic [CMD_W-1:0] TYPE_MASK      = 8'hE0;
    localparam logic [CMD_W-1:0] SUBS_MASK      = 8'h1F;
    localparam logic [CMD_W-1:0] TYPE_ASYNC_REQ = 8'h40;
    localparam logic [CMD_W-1:0] TYPE_SYNC_RSP  = 8'h60;
    localparam logic [CMD_W-1:0] SUBS_SYS       = 8'h01;
    localparam logic [CMD_W-1:0] SUBS_ZDO       = 8'h05;
    localparam logic [CMD_W-1:0] RESET_IND_CMD  = 8'h80;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCOPE_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCOPE_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCOPE_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCOPE_D = 3'd4;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 16'd200;
    localparam logic [CMD_W-1:0]    SCOPE_A_RESET = 8'd130;
    localparam logic [CMD_W-1:0]    SCOPE_B_RESET = 8'd132;
    localparam logic [CMD_W-1:0]    SCOPE_C_RESET = 8'd133;
    localparam logic [CMD_W-1:0]    SCOPE_D_RESET = 8'd202;

    typedef enum logic [2:0] {
        ROUTE_RESPONSE  = 3'd0,
        ROUTE_RESET_IND = 3'd1,
        ROUTE_DISPATCH  = 3'd2,
        ROUTE_DUPLICATE = 3'd3,
        ROUTE_UNEXPECTED = 3'd4
    } route_t;

    // Top -> ring scan request
    typedef struct packed {
        logic                start;
        logic [KEY_W-1:0]    key;
        logic [TIME_W-1:0]   now;
        logic [WINDOW_W-1:0] window;
    } ring_cmd_t;

    // Ring -> top scan result
    typedef struct packed {
        logic done;
        logic dup;
    } ring_sts_t;

    // Multiply by the FNV prime 16777619 = 2^24 + 0x193, as a shift-add.
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ src/frame_classifier_with_dedup_core.sv @@
// Top level of the frame classifier with windowed duplicate filter.
// Depends on fcd_pkg, fcd_hash and fcd_ring.
//
//  Channel  Dir  Handshake              Contents
//  s_       in   s_tvalid / s_tready    one payload byte of a command frame
//  m_       out  m_tvalid / m_tready    route and payload hash, one per frame
//  cfg_     in   cfg_valid / cfg_ready  register index and write data
//
// A payload byte is taken in S_IDLE and folded into the hash in S_HASH,
// and s_tready stays low until the fold is done. The frame-end byte of an
// in-scope request adds a ring scan through the shared compare unit, in
// which the record store reads one entry per cycle; other frame ends skip it.
// A finished result waits in the output register; the next frame's bytes
// are taken meanwhile, and only a new result stalls on m_tready.
// Reset is synchronous on aresetn low and empties the ring at once.
module frame_classifier_with_dedup_core import fcd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,   // cmd_high[7:0], cmd_low[15:8],
                                            // payload_byte[23:16], now_ms[55:24]
    input  logic                 s_tlast,   // frame_end
    input  logic                 s_tuser,   // byte_present
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // route[2:0], payload_hash[34:3], zeros
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [WINDOW_W-1:0] window_reg;
    logic [CMD_W-1:0]    scope_a_reg;
    logic [CMD_W-1:0]    scope_b_reg;
    logic [CMD_W-1:0]    scope_c_reg;
    logic [CMD_W-1:0]    scope_d_reg;

    // Captured input transfer
    logic [CMD_W-1:0]  cmd_high_reg;
    logic [CMD_W-1:0]  cmd_low_reg;
    logic [CMD_W-1:0]  payload_reg;
    logic [TIME_W-1:0] now_reg;
    logic              present_reg;
    logic              last_reg;

    // Frame result under construction and output register
    logic [HASH_W-1:0] frame_hash_reg;
    route_t            route_reg;
    logic              m_valid_reg;
    route_t            m_route_reg;
    logic [HASH_W-1:0] m_hash_reg;

    logic [HASH_W-1:0] hash_out;
    logic              hash_step;
    logic [CMD_W-1:0]  frame_type;
    logic [CMD_W-1:0]  frame_subs;
    logic              in_scope;
    logic              need_scan;
    route_t            class_route;
    logic              out_free;
    ring_cmd_t         ring_cmd;
    ring_sts_t         ring_sts;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'b0, m_hash_reg, m_route_reg};
    assign out_free  = !m_valid_reg || m_tready;

    // Fold the held byte into the hash in the cycle after the transfer
    assign hash_step = (state_reg == S_HASH);

    fcd_hash u_hash (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (hash_step),
        .data_byte    (payload_reg),
        .byte_present (present_reg),
        .frame_end    (last_reg),
        .hash_out     (hash_out)
    );

    // Classify by the type bits of cmd0; only in-scope ZDO requests are scanned
    assign frame_type = cmd_high_reg & TYPE_MASK;
    assign frame_subs = cmd_high_reg & SUBS_MASK;
    assign in_scope   = (cmd_low_reg == scope_a_reg) || (cmd_low_reg == scope_b_reg)
                     || (cmd_low_reg == scope_c_reg) || (cmd_low_reg == scope_d_reg);
    assign need_scan  = (frame_type == TYPE_ASYNC_REQ) && (frame_subs == SUBS_ZDO) && in_scope;

    always_comb begin
        if (frame_type == TYPE_SYNC_RSP) begin
            class_route = ROUTE_RESPONSE;
        end else if (frame_type == TYPE_ASYNC_REQ) begin
            if ((frame_subs == SUBS_SYS) && (cmd_low_reg == RESET_IND_CMD)) begin
                class_route = ROUTE_RESET_IND;
            end else begin
                class_route = ROUTE_DISPATCH;
            end
        end else begin
            class_route = ROUTE_UNEXPECTED;
        end
    end

    assign ring_cmd.start  = hash_step && last_reg && need_scan;
    assign ring_cmd.key    = {cmd_high_reg, cmd_low_reg, hash_out};
    assign ring_cmd.now    = now_reg;
    assign ring_cmd.window = window_reg;

    fcd_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ring_cmd),
        .sts     (ring_sts)
    );

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RESET;
            scope_a_reg <= SCOPE_A_RESET;
            scope_b_reg <= SCOPE_B_RESET;
            scope_c_reg <= SCOPE_C_RESET;
            scope_d_reg <= SCOPE_D_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WINDOW:  window_reg  <= cfg_data;
                CFG_SCOPE_A: scope_a_reg <= cfg_data[CMD_W-1:0];
                CFG_SCOPE_B: scope_b_reg <= cfg_data[CMD_W-1:0];
                CFG_SCOPE_C: scope_c_reg <= cfg_data[CMD_W-1:0];
                CFG_SCOPE_D: scope_d_reg <= cfg_data[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Retire the held result once the sink takes it; in S_EMIT the
            // emit below owns the output register
            if (m_valid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_high_reg <= s_tdata[7:0];
                        cmd_low_reg  <= s_tdata[15:8];
                        payload_reg  <= s_tdata[23:16];
                        now_reg      <= s_tdata[55:24];
                        present_reg  <= s_tuser;
                        last_reg     <= s_tlast;
                        state_reg    <= S_HASH;
                    end
                end
                S_HASH: begin
                    frame_hash_reg <= hash_out;
                    route_reg      <= class_route;
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (need_scan) begin
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_SCAN: begin
                    if (ring_sts.done) begin
                        route_reg <= ring_sts.dup ? ROUTE_DUPLICATE : ROUTE_DISPATCH;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_route_reg <= route_reg;
                        m_hash_reg  <= frame_hash_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/fcd_hash.sv @@
// Running FNV-1a hash accumulator, one payload byte per step.
// Depends on fcd_pkg (basis and shift-add prime multiply).
module fcd_hash import fcd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [CMD_W-1:0]  data_byte,
    input  logic              byte_present,
    input  logic              frame_end,
    output logic [HASH_W-1:0] hash_out
);

    logic [HASH_W-1:0] hash_reg;

    // Hash including the byte of this step
    assign hash_out = byte_present
                    ? fnv_mul(hash_reg ^ {{(HASH_W-CMD_W){1'b0}}, data_byte})
                    : hash_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= FNV_BASIS;
        end else if (step_en) begin
            hash_reg <= frame_end ? FNV_BASIS : hash_out;
        end
    end

endmodule

@@ src/fcd_ring.sv @@
// Duplicate ring: record storage plus one shared key/window compare unit
// that walks the entries one per cycle. Depends on fcd_pkg.
module fcd_ring import fcd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  ring_cmd_t cmd,
    output ring_sts_t sts
);

    localparam logic [RING_IDX_W-1:0] RING_LAST = RING_IDX_W'(RING_ENTRIES - 1);

    logic [KEY_W+TIME_W-1:0] mem [RING_ENTRIES];
    logic [RING_ENTRIES-1:0] valid_reg;
    logic [RING_IDX_W-1:0]   head_reg;
    logic [RING_IDX_W-1:0]   rd_idx_reg;
    logic                    issuing_reg;
    logic                    cmp_valid_reg;
    logic                    cmp_last_reg;
    logic                    dup_reg;
    logic                    done_reg;
    logic                    dup_out_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [WINDOW_W-1:0]     window_reg;
    logic [KEY_W+TIME_W-1:0] rd_entry_reg;
    logic                    rd_valid_reg;

    logic [TIME_W-1:0] age;
    logic              hit;
    logic              dup_any;
    logic              wr_en;

    assign age     = now_reg - rd_entry_reg[TIME_W-1:0];
    assign hit     = rd_valid_reg && (rd_entry_reg[KEY_W+TIME_W-1:TIME_W] == key_reg)
                  && (age < {{(TIME_W-WINDOW_W){1'b0}}, window_reg});
    assign dup_any = dup_reg | hit;
    assign wr_en   = cmp_valid_reg && cmp_last_reg && !dup_any;

    assign sts.done = done_reg;
    assign sts.dup  = dup_out_reg;

    // Scan control and head pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            head_reg      <= '0;
            rd_idx_reg    <= '0;
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            dup_reg       <= 1'b0;
            done_reg      <= 1'b0;
            dup_out_reg   <= 1'b0;
        end else begin
            done_reg      <= cmp_valid_reg && cmp_last_reg;
            cmp_valid_reg <= issuing_reg;
            cmp_last_reg  <= issuing_reg && (rd_idx_reg == RING_LAST);
            if (cmd.start) begin
                issuing_reg <= 1'b1;
                rd_idx_reg  <= '0;
                dup_reg     <= 1'b0;
                key_reg     <= cmd.key;
                now_reg     <= cmd.now;
                window_reg  <= cmd.window;
            end else if (issuing_reg) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == RING_LAST) begin
                    issuing_reg <= 1'b0;
                end
            end
            if (cmp_valid_reg) begin
                dup_reg <= dup_any;
                if (cmp_last_reg) begin
                    dup_out_reg <= dup_any;
                end
            end
            // A record made at time zero stays empty, but the head still moves
            if (wr_en) begin
                valid_reg[head_reg] <= (now_reg != '0);
                head_reg <= (head_reg == RING_LAST) ? '0 : head_reg + 1'b1;
            end
        end
    end

    // Record storage: one write port at the head, one registered read port
    always_ff @(posedge aclk) begin
        rd_entry_reg <= mem[rd_idx_reg];
        rd_valid_reg <= valid_reg[rd_idx_reg];
        if (wr_en) begin
            mem[head_reg] <= {key_reg, now_reg};
        end
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for frame_classifier_with_dedup_core: random command frames in,
// route and FNV-1a payload hash out, checked against an in-bench predictor of the dedup ring.
// Depends on fcd_pkg and the RTL sources under src/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fcd_pkg::*;

    // Hold the pause after the last result long enough for a ring scan in flight.
    localparam int SETTLE_CYCLES = RING_ENTRIES + 8;
    localparam int REPORT_LIMIT  = 10;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct {
        bit [7:0]  cmd_high;
        bit [7:0]  cmd_low;
        bit [7:0]  payload;
        bit        present;
        bit        last;
        bit [31:0] now_ms;
    } frame_item_t;

    typedef struct {
        route_t    route;
        bit [31:0] hash;
    } frame_verdict_t;

    // An in-scope request already sent, kept so that it can be replayed as a duplicate.
    typedef struct {
        bit [7:0]  cmd_low;
        bit [31:0] stamp;
        int        len;
        bit [63:0] body;
    } sent_request_t;

    // Predicts the route and hash of every frame and checks the result transfers in order.
    class route_tracker;
        bit [15:0]      window;
        bit [7:0]       scope [4];
        bit [31:0]      fold;
        bit [47:0]      seen_key   [RING_ENTRIES];
        bit [31:0]      seen_stamp [RING_ENTRIES];
        int             seen_head;
        frame_verdict_t due [$];
        int             errors;
        int             frames;
        int             drops;

        function new();
            window   = WINDOW_RESET;
            scope[0] = SCOPE_A_RESET;
            scope[1] = SCOPE_B_RESET;
            scope[2] = SCOPE_C_RESET;
            scope[3] = SCOPE_D_RESET;
            fold     = FNV_BASIS;
            for (int i = 0; i < RING_ENTRIES; i++) begin
                seen_key[i]   = '0;
                seen_stamp[i] = '0;
            end
            seen_head = 0;
            errors    = 0;
            frames    = 0;
            drops     = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] value);
            case (idx)
                CFG_WINDOW:  window   = value;
                CFG_SCOPE_A: scope[0] = value[7:0];
                CFG_SCOPE_B: scope[1] = value[7:0];
                CFG_SCOPE_C: scope[2] = value[7:0];
                CFG_SCOPE_D: scope[3] = value[7:0];
                default: ;
            endcase
        endfunction

        // Scan for a live record of this key inside the window; on a miss record it.
        function bit seen_recently(bit [47:0] key, bit [31:0] now);
            bit [31:0] age;
            for (int i = 0; i < RING_ENTRIES; i++) begin
                age = now - seen_stamp[i];
                if (seen_stamp[i] != 0 && seen_key[i] == key && age < {16'd0, window})
                    return 1'b1;
            end
            seen_key[seen_head]   = key;
            seen_stamp[seen_head] = now;
            seen_head = (seen_head + 1) % RING_ENTRIES;
            return 1'b0;
        endfunction

        function void take_item(frame_item_t it);
            frame_verdict_t v;
            bit [7:0]       kind;
            bit [7:0]       subsys;
            bit             scoped;
            if (it.present)
                fold = (fold ^ {24'd0, it.payload}) * 32'd16777619;
            if (!it.last)
                return;
            v.hash = fold;
            fold   = FNV_BASIS;
            kind   = it.cmd_high & TYPE_MASK;
            subsys = it.cmd_high & SUBS_MASK;
            scoped = it.cmd_low == scope[0] || it.cmd_low == scope[1] ||
                     it.cmd_low == scope[2] || it.cmd_low == scope[3];
            if (kind == TYPE_SYNC_RSP)
                v.route = ROUTE_RESPONSE;
            else if (kind != TYPE_ASYNC_REQ)
                v.route = ROUTE_UNEXPECTED;
            else if (subsys == SUBS_SYS && it.cmd_low == RESET_IND_CMD)
                v.route = ROUTE_RESET_IND;
            else if (subsys == SUBS_ZDO && scoped)
                v.route = seen_recently({it.cmd_high, it.cmd_low, v.hash}, it.now_ms) ?
                          ROUTE_DUPLICATE : ROUTE_DISPATCH;
            else
                v.route = ROUTE_DISPATCH;
            if (v.route == ROUTE_DUPLICATE)
                drops++;
            due.push_back(v);
        endfunction

        function void match_result(logic [39:0] data);
            frame_verdict_t v;
            frames++;
            if (due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result transfer: route %0d hash %h",
                             data[2:0], data[34:3]);
                return;
            end
            v = due.pop_front();
            if (data[2:0] !== v.route || data[34:3] !== v.hash || data[39:35] !== 5'd0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("frame %0d mismatch: route exp %0d got %0d, %s %h got %h, pad %b",
                             frames, v.route, data[2:0], "hash exp", v.hash, data[34:3],
                             data[39:35]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [55:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    route_tracker  track = new();
    sent_request_t replay_pool [$];
    bit            s_idle_on = 1'b1;
    bit            m_idle_on = 1'b1;
    bit [31:0]     clock_ms;
    int            n_items   = 0;
    int            n_writes  = 0;
    int            n_phases  = 0;

    frame_classifier_with_dedup_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("run timed out with %0d results outstanding", track.due.size());
        $display("status: fail");
        $finish;
    end

    function automatic int idle_cycles(bit enabled);
        return enabled ? $urandom_range(0, 9) : 0;
    endfunction

    function automatic bit [7:0] rand_byte();
        return 8'($urandom());
    endfunction

    function automatic frame_item_t random_item();
        frame_item_t it;
        it.cmd_high = rand_byte();
        it.cmd_low  = rand_byte();
        it.payload  = rand_byte();
        it.present  = 1'($urandom_range(0, 1));
        it.last     = 1'($urandom_range(0, 1));
        it.now_ms   = $urandom();
        return it;
    endfunction

    // Age of a replay relative to the last send: aim at the window edges.
    function automatic bit [31:0] replay_age(bit [15:0] win);
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return {16'd0, win} - 32'd1;
            3:       return {16'd0, win};
            4:       return {16'd0, win} + 32'd1;
            5:       return $urandom_range(0, 2 * win + 2);
            default: return $urandom();
        endcase
    endfunction

    // Offer one item; keep tvalid high across back-to-back transfers.
    task automatic send_item(input frame_item_t it);
        int gap;
        gap = idle_cycles(s_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.now_ms, it.payload, it.cmd_low, it.cmd_high};
        s_tlast  <= it.last;
        s_tuser  <= it.present;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track.take_item(it);
        n_items++;
    endtask

    // Send a frame of len bytes (byte k in body[8k+:8]). A zero-length frame is one
    // absent-byte item. With scatter set, mix in absent bytes and junk command/time fields on
    // non-final items, since only the final item's command bytes and time count.
    task automatic send_frame(input bit [7:0] c0, input bit [7:0] c1, input bit [31:0] now,
                              input int len, input bit [63:0] body, input bit scatter);
        frame_item_t it;
        bit          tail_hole;
        tail_hole = (len == 0) || (scatter && $urandom_range(0, 7) == 0);
        for (int k = 0; k < len; k++) begin
            if (scatter && $urandom_range(0, 7) == 0) begin
                it         = random_item();
                it.present = 1'b0;
                it.last    = 1'b0;
                send_item(it);
            end
            it.cmd_high = c0;
            it.cmd_low  = c1;
            it.payload  = body[8*k +: 8];
            it.present  = 1'b1;
            it.last     = (k == len - 1) && !tail_hole;
            it.now_ms   = now;
            if (scatter && !it.last && $urandom_range(0, 1) == 1) begin
                it.cmd_high = rand_byte();
                it.cmd_low  = rand_byte();
                it.now_ms   = $urandom();
            end
            send_item(it);
        end
        if (tail_hole) begin
            it.cmd_high = c0;
            it.cmd_low  = c1;
            it.payload  = rand_byte();
            it.present  = 1'b0;
            it.last     = 1'b1;
            it.now_ms   = now;
            send_item(it);
        end
    endtask

    // Leave cfg_valid high; the next phase lowers it, so back-to-back writes need no gap.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        track.write_reg(idx, value);
        n_writes++;
    endtask

    // Random codes, with junk in the upper byte that the block must mask off.
    task automatic shuffle_scopes();
        write_reg(CFG_SCOPE_A, 16'($urandom()));
        write_reg(CFG_SCOPE_B, 16'($urandom()));
        write_reg(CFG_SCOPE_C, 16'($urandom()));
        write_reg(CFG_SCOPE_D, 16'($urandom()));
    endtask

    // Stop offering input, wait out every expected result, then let the block go quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (track.due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random frame. About half are in-scope requests, half of those replays of an
    // earlier one so the ring sees hits, misses at the window edge and near misses.
    task automatic random_frame();
        bit [7:0]      c0;
        bit [7:0]      c1;
        bit [2:0]      kind;
        bit [31:0]     now;
        bit [63:0]     body;
        int            len;
        int            pick;
        int            j;
        sent_request_t req;
        frame_item_t   it;

        // Toggle idling per side now and then, so both gappy and solid stretches occur.
        if ($urandom_range(0, 19) == 0) s_idle_on = !s_idle_on;
        if ($urandom_range(0, 19) == 0) m_idle_on = !m_idle_on;
        if ($urandom_range(0, 15) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 40);
        now  = clock_ms;
        body = {$urandom(), $urandom()};
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        pick = $urandom_range(0, 99);

        if (pick < 4) begin
            // Stray item, possibly ending whatever frame is open.
            it = random_item();
            send_item(it);
            return;
        end

        if (pick < 30 || (pick < 55 && replay_pool.size() == 0)) begin
            c0 = TYPE_ASYNC_REQ | SUBS_ZDO;
            c1 = track.scope[$urandom_range(0, 3)];
            // A record stamped at time zero stays empty.
            if ($urandom_range(0, 49) == 0)
                now = '0;
            req.cmd_low = c1;
            req.stamp   = now;
            req.len     = len;
            req.body    = body;
            replay_pool.push_back(req);
            if (replay_pool.size() > 6)
                void'(replay_pool.pop_front());
        end else if (pick < 55) begin
            j    = $urandom_range(0, replay_pool.size() - 1);
            req  = replay_pool[j];
            c0   = TYPE_ASYNC_REQ | SUBS_ZDO;
            c1   = req.cmd_low;
            len  = req.len;
            body = req.body;
            now  = req.stamp + replay_age(track.window);
            case ($urandom_range(0, 7))
                0:       c1 = track.scope[$urandom_range(0, 3)];
                1:       body[0] = !body[0];
                default: ;
            endcase
            req.stamp      = now;
            replay_pool[j] = req;
        end else if (pick < 62) begin
            c0 = TYPE_ASYNC_REQ | SUBS_SYS;
            c1 = RESET_IND_CMD;
        end else if (pick < 72) begin
            c0 = TYPE_SYNC_RSP | (rand_byte() & SUBS_MASK);
            c1 = rand_byte();
        end else if (pick < 84) begin
            c0 = TYPE_ASYNC_REQ | (rand_byte() & SUBS_MASK);
            c1 = rand_byte();
        end else if (pick < 92) begin
            // Type codes other than request and response: 0, 1, 4..7.
            kind = 3'($urandom_range(0, 5));
            if (kind >= 3'd2)
                kind = kind + 3'd2;
            c0 = {kind, 5'(rand_byte())};
            c1 = rand_byte();
        end else begin
            c0 = rand_byte();
            c1 = rand_byte();
        end
        send_frame(c0, c1, now, len, body, 1'b1);
    endtask

    task automatic run_phase(input int target);
        int first;
        first = n_items;
        cfg_valid <= 1'b0;
        n_phases++;
        while (n_items - first < target)
            random_frame();
        drain();
    endtask

    // Result side: stall a random number of cycles before each transfer, then check it.
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_cycles(m_idle_on);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            track.match_result(m_tdata);
        end
    end

    initial begin : stimulus
        frame_item_t it;
        clock_ms = 32'd1000;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset settings (window 200).
        // Empty payload: hash stays at the offset basis.
        send_frame(TYPE_SYNC_RSP, 8'h00, 32'd5, 0, 64'h0, 1'b0);
        send_frame(TYPE_ASYNC_REQ | SUBS_SYS, RESET_IND_CMD, 32'd10, 2, 64'h00FF, 1'b0);
        send_frame(TYPE_ASYNC_REQ | SUBS_SYS, 8'h81, 32'd20, 1, 64'h7E, 1'b0);
        // Window edge: age 199 drops, age 200 passes and is recorded again.
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_A_RESET, 32'd100, 1, 64'hA5, 1'b0);
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_A_RESET, 32'd299, 1, 64'hA5, 1'b0);
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_A_RESET, 32'd300, 1, 64'hA5, 1'b0);
        // Unexpected types at both ends of the cmd0 range.
        send_frame(8'hFF, 8'hFF, 32'd40, 1, 64'h00, 1'b0);
        send_frame(8'h1F, 8'h00, 32'd41, 0, 64'h0, 1'b0);
        // Records made at time zero stay empty, so the repeat is not a duplicate.
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_B_RESET, 32'd0, 1, 64'h11, 1'b0);
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_B_RESET, 32'd0, 1, 64'h11, 1'b0);
        // Age measured across the 32-bit time wrap.
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_D_RESET, 32'hFFFF_FFF0, 0, 64'h0, 1'b0);
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, SCOPE_D_RESET, 32'h0000_0010, 0, 64'h0, 1'b0);
        // ZDO request with a code outside the scope list.
        send_frame(TYPE_ASYNC_REQ | SUBS_ZDO, 8'h00, 32'd50, 2, 64'h0201, 1'b0);
        // Command bytes come from the final item; absent bytes leave the hash alone.
        it = '{8'h45, SCOPE_C_RESET, 8'h12, 1'b1, 1'b0, 32'd61};
        send_item(it);
        it = '{8'h00, 8'h00, 8'hEE, 1'b0, 1'b0, 32'hFFFF_FFFF};
        send_item(it);
        it = '{TYPE_SYNC_RSP | SUBS_ZDO, 8'h55, 8'h99, 1'b0, 1'b1, 32'd62};
        send_item(it);
        drain();

        run_phase(220);

        // Narrowest non-zero window, overlapping codes, masking and unmapped indexes.
        write_reg(CFG_WINDOW, 16'd1);
        write_reg(CFG_SCOPE_A, 16'hFF00);
        write_reg(CFG_SCOPE_B, 16'h0100);
        write_reg(CFG_SCOPE_C, 16'h5A00);
        write_reg(CFG_SCOPE_D, 16'h00FF);
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'h1234);
        run_phase(160);

        // Widest window.
        write_reg(CFG_WINDOW, 16'hFFFF);
        shuffle_scopes();
        run_phase(160);

        // Zero window: nothing can match.
        write_reg(CFG_WINDOW, 16'd0);
        run_phase(120);

        write_reg(CFG_WINDOW, 16'($urandom_range(1, 2000)));
        shuffle_scopes();
        write_reg(CFG_UNUSED_LO, 16'($urandom()));
        run_phase(200);

        if (track.due.size() != 0)
            $display("%0d expected results never arrived", track.due.size());
        $display("covered %0d input transfers and %0d result transfers, %0d duplicate drops",
                 n_items, track.frames, track.drops);
        $display("%0d register writes across %0d settings, windows 0, 1, 65535 included",
                 n_writes, n_phases);
        if (track.errors == 0 && track.due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", track.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
